// ----- src/wpi_pkg.sv -----
// ----------------------------------------------------------------------------
// wpi_pkg
// Shared types, widths and codes for the waypoint path interpolator.
// ----------------------------------------------------------------------------
package wpi_pkg;

  localparam int COORD_BITS = 24;
  localparam int STEP_BITS  = 6;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int CNT_BITS   = $clog2(MAG_BITS);
  localparam int AXES       = 3;
  localparam int AXIS_BITS  = 2;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [STEP_BITS-1:0] MAX_STEPS   = STEP_BITS'(63);
  localparam logic [STEP_BITS-1:0] STEPS_RESET = STEP_BITS'(8);

  localparam logic REG_STEPS = 1'b0;

  localparam logic [AXIS_BITS-1:0] AXIS_FIRST = AXIS_BITS'(0);
  localparam logic [AXIS_BITS-1:0] AXIS_LAST  = AXIS_BITS'(AXES - 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [STEP_BITS-1:0]         steps_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic   start;
    diff_t  dividend;
    steps_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    coord_t quotient;
  } div_rsp_t;

endpackage

// ----- src/wpi_in_if.sv -----
// ----------------------------------------------------------------------------
// wpi_in_if
// Waypoint channel: valid/ready handshake with one waypoint per beat.
// ----------------------------------------------------------------------------
interface wpi_in_if import wpi_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   new_path;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;

  modport source (output valid, output new_path, output point_x, output point_y,
                  output point_z, input ready);
  modport sink   (input valid, input new_path, input point_x, input point_y,
                  input point_z, output ready);
endinterface

// ----- src/wpi_out_if.sv -----
// ----------------------------------------------------------------------------
// wpi_out_if
// Frame channel: valid/ready handshake with one frame per beat.
// ----------------------------------------------------------------------------
interface wpi_out_if import wpi_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t frame_x;
  coord_t frame_y;
  coord_t frame_z;
  logic   last_frame;

  modport source (output valid, output frame_x, output frame_y, output frame_z,
                  output last_frame, input ready);
  modport sink   (input valid, input frame_x, input frame_y, input frame_z,
                  input last_frame, output ready);
endinterface

// ----- src/wpi_cfg.sv -----
// ----------------------------------------------------------------------------
// wpi_cfg
// APB register slave holding the step count per segment.
// ----------------------------------------------------------------------------
module wpi_cfg import wpi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output steps_t                   steps_o
);

  steps_t steps_q, steps_d;
  logic   sel_steps;

  assign pready    = 1'b1;
  assign sel_steps = (paddr[APB_ADDR_BITS-1] == REG_STEPS);

  always_comb begin
    steps_d = steps_q;
    if (psel && penable && pwrite && pready && sel_steps) begin
      steps_d = pwdata[STEP_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEPS_RESET;
    end else begin
      steps_q <= steps_d;
    end
  end

  assign prdata  = sel_steps ? APB_DATA_BITS'(steps_q) : '0;
  assign steps_o = steps_q;

endmodule

// ----- src/wpi_divider.sv -----
// ----------------------------------------------------------------------------
// wpi_divider
// Radix-2 restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module wpi_divider import wpi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [MAG_BITS-1:0]  dvd_q, dvd_d;
  steps_t               rem_q, rem_d;
  steps_t               dsr_q, dsr_d;
  logic                 neg_q, neg_d;

  logic [DIFF_BITS-1:0] dvd_neg;
  logic [STEP_BITS:0]   trial;
  logic                 fits;

  assign dvd_neg = -req_i.dividend;
  assign trial   = {rem_q, dvd_q[MAG_BITS-1]};
  assign fits    = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      neg_d  = req_i.dividend[DIFF_BITS-1];
      dvd_d  = req_i.dividend[DIFF_BITS-1] ? dvd_neg[MAG_BITS-1:0]
                                           : req_i.dividend[MAG_BITS-1:0];
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when the divisor fits
      rem_d = fits ? STEP_BITS'(trial - {1'b0, dsr_q}) : trial[STEP_BITS-1:0];
      dvd_d = {dvd_q[MAG_BITS-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_BITS'(MAG_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? coord_t'(-dvd_q) : coord_t'(dvd_q);

endmodule

// ----- src/waypoint_path_interpolator.sv -----
// ----------------------------------------------------------------------------
// waypoint_path_interpolator
// Linear 3D path interpolation between consecutive fixed-point waypoints.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  in_i    | in  | valid / ready      | new_path, point_x/y/z (s24, 20 frac)
//  out_o   | out | valid / ready      | frame_x/y/z (s24, 20 frac), last_frame
//  apb     | in  | psel/penable/pready| steps_per_segment at byte address 0
//
//  A waypoint that opens a path, or arrives with nothing stored, is only
//  stored. For any other waypoint the difference to the stored one is divided
//  by the step count in the shared divider (one bit per cycle, x then y then
//  z), then S+1 frames follow at one per cycle when out_o is ready. Stalls on
//  out_o hold the current frame; in_i is not ready until the last frame beat
//  is taken. Reset clears the stored waypoint and sets the step count to 8.
// ----------------------------------------------------------------------------
module waypoint_path_interpolator import wpi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  wpi_in_if.sink                   in_i,
  wpi_out_if.source                out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  state_e                state_q, state_d;
  logic                  have_prev_q, have_prev_d;
  logic [AXIS_BITS-1:0]  axis_q, axis_d;
  steps_t                k_q, k_d;
  steps_t                s_q;

  coord_t                prev_q  [AXES];
  coord_t                pt_q    [AXES];
  coord_t                inc_q   [AXES];
  coord_t                frame_q [AXES];

  steps_t                steps;
  steps_t                s_eff;
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic                  in_acc;
  logic                  out_acc;
  logic                  seg_start;
  logic                  is_last;
  logic [AXIS_BITS-1:0]  sel_a;
  coord_t                sel_pt;
  coord_t                sel_prev;

  wpi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .steps_o (steps)
  );

  wpi_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // zero means one step, anything above the cap saturates
  assign s_eff = (steps == '0) ? STEP_BITS'(1) : ((steps > MAX_STEPS) ? MAX_STEPS : steps);

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign seg_start  = in_acc && !in_i.new_path && have_prev_q;
  assign is_last    = (k_q == s_q);

  // next axis to divide: x straight from the port, y and z from the latched point
  assign sel_a    = (axis_q == AXIS_LAST) ? AXIS_FIRST : axis_q + 1'b1;
  assign sel_pt   = (state_q == ST_IDLE) ? in_i.point_x : pt_q[sel_a];
  assign sel_prev = (state_q == ST_IDLE) ? prev_q[AXIS_FIRST] : prev_q[sel_a];

  assign div_req.dividend = diff_t'(sel_pt) - diff_t'(sel_prev);
  assign div_req.divisor  = (state_q == ST_IDLE) ? s_eff : s_q;
  assign div_req.start    = seg_start ||
                            ((state_q == ST_DIV) && div_rsp.done && (axis_q != AXIS_LAST));

  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    axis_d      = axis_q;
    k_d         = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          axis_d = AXIS_FIRST;
          if (seg_start) begin
            state_d = ST_DIV;
          end else begin
            have_prev_d = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (axis_q == AXIS_LAST) begin
            state_d = ST_EMIT;
            k_d     = '0;
          end else begin
            axis_d = sel_a;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (is_last) begin
            state_d     = ST_IDLE;
            have_prev_d = 1'b1;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      axis_q      <= AXIS_FIRST;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      axis_q      <= axis_d;
      k_q         <= k_d;
    end
  end

  // stored waypoint: load on a path start or with nothing stored, or after the last frame beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        prev_q[a] <= '0;
      end
    end else if (in_acc && !seg_start) begin
      prev_q[0] <= in_i.point_x;
      prev_q[1] <= in_i.point_y;
      prev_q[2] <= in_i.point_z;
    end else if ((state_q == ST_EMIT) && out_acc && is_last) begin
      for (int a = 0; a < AXES; a++) begin
        prev_q[a] <= pt_q[a];
      end
    end
  end

  // payload: latched point, increments, running frame
  always_ff @(posedge clk_i) begin
    if (seg_start) begin
      pt_q[0] <= in_i.point_x;
      pt_q[1] <= in_i.point_y;
      pt_q[2] <= in_i.point_z;
      s_q     <= s_eff;
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      inc_q[axis_q] <= div_rsp.quotient;
      if (axis_q == AXIS_LAST) begin
        for (int a = 0; a < AXES; a++) begin
          frame_q[a] <= prev_q[a];
        end
      end
    end
    if ((state_q == ST_EMIT) && out_acc && !is_last) begin
      for (int a = 0; a < AXES; a++) begin
        frame_q[a] <= frame_q[a] + inc_q[a];
      end
    end
  end

  assign out_o.valid      = (state_q == ST_EMIT);
  assign out_o.frame_x    = frame_q[0];
  assign out_o.frame_y    = frame_q[1];
  assign out_o.frame_z    = frame_q[2];
  assign out_o.last_frame = is_last;

`ifndef SYNTHESIS
  // never take a waypoint while a frame is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_i.ready && out_o.valid))
    else $error("input ready while frames pending");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider done outside divide phase");

  // after the last frame beat, the block is ready for the next waypoint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_frame) |=> in_i.ready)
    else $error("not ready after last frame");

  // the frame index never passes the latched step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((k_q <= s_q) && (s_q != '0)))
    else $error("frame index out of range");
`endif

endmodule
